FILE: sv/json_string_escaper_utf8_check_unit_macros.svh
// Assertion macros shared by the escaper RTL.
`ifndef JSON_STRING_ESCAPER_UTF8_CHECK_UNIT_MACROS_SVH
`define JSON_STRING_ESCAPER_UTF8_CHECK_UNIT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define JSEU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define JSEU_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/jseu_pkg.sv
// Shared types, constants and helper functions of the JSON string escaper.
`default_nettype none
package jseu_pkg;
	localparam int MAX_RESULTS = 8;
	localparam int CNT_W = $clog2(MAX_RESULTS);
	localparam int JOB_QUEUE_DEPTH = 2;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NONE = 8'h00;
	localparam logic [7:0] CTRL_LIMIT = 8'd32;

	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] data;
		logic [CNT_W-1:0] last_idx;
		logic bad;
		logic done;
	} job_t;

	function automatic logic [7:0] esc_char(input logic [7:0] c);
		logic [7:0] e;
		unique case (c)
			8'h5C: e = CH_BSLASH;
			8'h22: e = CH_QUOTE;
			8'h08: e = 8'h62;
			8'h09: e = 8'h74;
			8'h0A: e = 8'h6E;
			8'h0C: e = 8'h66;
			8'h0D: e = 8'h72;
			default: e = CH_NONE;
		endcase
		return e;
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		logic [7:0] d;
		if (n < 4'd10) begin
			d = CH_ZERO + {4'b0, n};
		end else begin
			d = 8'h57 + {4'b0, n};
		end
		return d;
	endfunction
endpackage
`default_nettype wire

FILE: sv/jseu_front.sv
// Front end: accepts input words, decodes UTF-8 and builds at most one output job per word.
`default_nettype none
`include "json_string_escaper_utf8_check_unit_macros.svh"
module jseu_front
	import jseu_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] in_byte,
	input  wire logic       has_byte,
	input  wire logic       start_of_string,
	input  wire logic       end_of_string,
	input  wire logic       q_ready,
	output logic            q_push,
	output job_t            q_job
);
	localparam int HeldDepth = 3;

	logic inside_q;
	logic drop_q;
	logic [1:0] need_q;
	logic [1:0] len_q;
	logic [7:0] held_q [HeldDepth];

	logic v_inside;
	logic v_drop;
	logic [1:0] v_need;
	logic [1:0] v_len;
	logic [7:0] v_held [HeldDepth];
	logic [CNT_W:0] v_n;
	job_t v_job;
	logic [2:0] total;
	logic [2:0] pos3;
	logic [1:0] pos;
	logic [7:0] lo;
	logic [7:0] hi;
	logic [7:0] esc;
	logic accept;

	assign s_tready = q_ready;
	assign accept = s_tvalid && q_ready;

	always_comb begin
		v_inside = inside_q;
		v_drop = drop_q;
		v_need = need_q;
		v_len = len_q;
		v_held = held_q;
		v_n = '0;
		v_job = '0;
		total = 3'd0;
		pos3 = 3'd0;
		pos = 2'd0;
		lo = 8'h80;
		hi = 8'hBF;
		esc = esc_char(in_byte);
		if (start_of_string) begin
			v_inside = 1'b1;
			v_drop = 1'b0;
			v_need = 2'd0;
			v_len = 2'd0;
			v_job.data[v_n[CNT_W-1:0]] = CH_QUOTE;
			v_n = v_n + 1'b1;
		end
		if (v_inside) begin
			if (has_byte && !v_drop) begin
				if (v_need == 2'd0) begin
					if (in_byte < 8'h80) begin
						if (esc != CH_NONE) begin
							v_job.data[v_n[CNT_W-1:0]] = CH_BSLASH;
							v_n = v_n + 1'b1;
							v_job.data[v_n[CNT_W-1:0]] = esc;
							v_n = v_n + 1'b1;
						end else if (in_byte < CTRL_LIMIT) begin
							v_job.data[v_n[CNT_W-1:0]] = CH_BSLASH;
							v_n = v_n + 1'b1;
							v_job.data[v_n[CNT_W-1:0]] = CH_U;
							v_n = v_n + 1'b1;
							v_job.data[v_n[CNT_W-1:0]] = CH_ZERO;
							v_n = v_n + 1'b1;
							v_job.data[v_n[CNT_W-1:0]] = CH_ZERO;
							v_n = v_n + 1'b1;
							v_job.data[v_n[CNT_W-1:0]] = hex_digit(in_byte[7:4]);
							v_n = v_n + 1'b1;
							v_job.data[v_n[CNT_W-1:0]] = hex_digit(in_byte[3:0]);
							v_n = v_n + 1'b1;
						end else begin
							v_job.data[v_n[CNT_W-1:0]] = in_byte;
							v_n = v_n + 1'b1;
						end
					end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
						v_len = 2'd2;
						v_need = 2'd1;
						v_held[0] = in_byte;
					end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
						v_len = 2'd3;
						v_need = 2'd2;
						v_held[0] = in_byte;
					end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
						v_len = 2'd0;
						v_need = 2'd3;
						v_held[0] = in_byte;
					end else begin
						v_drop = 1'b1;
						v_need = 2'd0;
						v_len = 2'd0;
						v_job.data[v_n[CNT_W-1:0]] = CH_NONE;
						v_job.bad = 1'b1;
						v_job.done = 1'b1;
						v_n = v_n + 1'b1;
					end
				end else begin
					total = (v_len == 2'd0) ? 3'd4 : {1'b0, v_len};
					pos3 = total - {1'b0, v_need};
					pos = pos3[1:0];
					if (pos == 2'd1) begin
						priority if (v_held[0] == 8'hE0) begin
							lo = 8'hA0;
						end else if (v_held[0] == 8'hED) begin
							hi = 8'h9F;
						end else if (v_held[0] == 8'hF0) begin
							lo = 8'h90;
						end else if (v_held[0] == 8'hF4) begin
							hi = 8'h8F;
						end else begin
							lo = 8'h80;
						end
					end
					if (in_byte < lo || in_byte > hi) begin
						v_drop = 1'b1;
						v_need = 2'd0;
						v_len = 2'd0;
						v_job.data[v_n[CNT_W-1:0]] = CH_NONE;
						v_job.bad = 1'b1;
						v_job.done = 1'b1;
						v_n = v_n + 1'b1;
					end else begin
						if (pos != 2'd3) begin
							v_held[pos] = in_byte;
						end
						v_need = v_need - 2'd1;
						if (v_need == 2'd0) begin
							for (int i = 0; i < HeldDepth; i++) begin
								if (2'(i) < pos) begin
									v_job.data[v_n[CNT_W-1:0]] = v_held[i];
									v_n = v_n + 1'b1;
								end
							end
							v_job.data[v_n[CNT_W-1:0]] = in_byte;
							v_n = v_n + 1'b1;
							v_len = 2'd0;
						end
					end
				end
			end
			if (end_of_string) begin
				if (!v_drop) begin
					if (v_need != 2'd0) begin
						v_job.data[v_n[CNT_W-1:0]] = CH_NONE;
						v_job.bad = 1'b1;
					end else begin
						v_job.data[v_n[CNT_W-1:0]] = CH_QUOTE;
					end
					v_job.done = 1'b1;
					v_n = v_n + 1'b1;
				end
				v_inside = 1'b0;
				v_drop = 1'b0;
				v_need = 2'd0;
				v_len = 2'd0;
			end
		end
		v_job.last_idx = CNT_W'(v_n - 1'b1);
	end

	assign q_push = accept && (v_n != '0);
	assign q_job = v_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			drop_q <= 1'b0;
			need_q <= 2'd0;
			len_q <= 2'd0;
		end else if (accept) begin
			inside_q <= v_inside;
			drop_q <= v_drop;
			need_q <= v_need;
			len_q <= v_len;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= v_held;
		end
	end

	`JSEU_ASSERT(a_need_inside, clk, arst_n, need_q != '0 |-> inside_q && !drop_q, "front: stray char")
	`JSEU_ASSERT(a_drop_inside, clk, arst_n, drop_q |-> inside_q, "front: drop outside string")
	`JSEU_ASSERT(a_start_pushes, clk, arst_n, accept && start_of_string |-> q_push, "front: no start job")
endmodule
`default_nettype wire

FILE: sv/jseu_queue.sv
// Short job queue between the front end and the back end.
`default_nettype none
`include "json_string_escaper_utf8_check_unit_macros.svh"
module jseu_queue
	import jseu_pkg::*;
#(
	parameter int Depth = JOB_QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_push,
	input  wire job_t in_job,
	output logic      in_ready,
	output logic      out_valid,
	output job_t      out_job,
	input  wire logic out_pop
);
	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);

	job_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign in_ready = count_q != CntW'(Depth);
	assign out_valid = count_q != '0;
	assign out_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (in_push) begin
			mem_q[wr_ptr_q] <= in_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (in_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (out_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (in_push && !out_pop) begin
				count_q <= count_q + 1'b1;
			end else if (out_pop && !in_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`JSEU_ASSERT(a_count_bound, clk, arst_n, count_q <= CntW'(Depth), "queue: count above depth")
	`JSEU_ASSERT(a_push_ready, clk, arst_n, in_push |-> in_ready, "queue: push while full")
	`JSEU_ASSERT(a_pop_valid, clk, arst_n, out_pop |-> out_valid, "queue: pop while empty")
	`JSEU_ASSERT(a_count_up, clk, arst_n, in_push && !out_pop |=> count_q == $past(count_q) + 1'b1, "queue: count did not advance on push")
endmodule
`default_nettype wire

FILE: sv/jseu_back.sv
// Back end: serializes the head job of the queue one output word per cycle while m_tready is high.
`default_nettype none
module jseu_back
	import jseu_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	input  wire job_t  q_job,
	output logic       q_pop,
	output logic       m_tvalid,
	input  wire logic  m_tready,
	output logic [15:0] m_tdata,
	output logic       m_tuser,
	output logic       m_tlast
);
	logic [CNT_W-1:0] idx_q;
	logic last_word;
	logic fire;

	assign last_word = idx_q == q_job.last_idx;
	assign fire = m_tvalid && m_tready;
	assign q_pop = fire && last_word;

	assign m_tvalid = q_valid;
	assign m_tdata = {7'b0, last_word, q_job.data[idx_q]};
	assign m_tuser = last_word && q_job.bad;
	assign m_tlast = last_word && q_job.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (q_pop) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

FILE: sv/json_string_escaper_utf8_check_unit.sv
// The job of an accepted input word is registered in the job queue, whose head job the back end offers as output.
// Throughput: one input word per cycle while each makes one output word and m_tready is high; a word that makes
// k output words (at most 8) holds the back end until all k are taken, set by the one-word output port.
// The job queue of QueueDepth entries lets the front end keep accepting meanwhile.
// Reset: arst_n asynchronously clears decoder state, queue and output position.
`default_nettype none
module json_string_escaper_utf8_check_unit
	import jseu_pkg::*;
#(
	parameter int QueueDepth = JOB_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] in_byte
	input  wire logic [1:0]  s_tuser,  // [0] has_byte, [1] start_of_string
	input  wire logic        s_tlast,  // end_of_string
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // [7:0] out_byte, [8] run_last, [15:9] zero
	output logic             m_tuser,  // bad_utf8
	output logic             m_tlast   // string_done
);
	logic q_ready;
	logic q_push;
	job_t q_in_job;
	logic q_valid;
	job_t q_out_job;
	logic q_pop;

	jseu_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.in_byte(s_tdata),
		.has_byte(s_tuser[0]),
		.start_of_string(s_tuser[1]),
		.end_of_string(s_tlast),
		.q_ready(q_ready),
		.q_push(q_push),
		.q_job(q_in_job)
	);

	jseu_queue #(
		.Depth(QueueDepth)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.in_push(q_push),
		.in_job(q_in_job),
		.in_ready(q_ready),
		.out_valid(q_valid),
		.out_job(q_out_job),
		.out_pop(q_pop)
	);

	jseu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_job(q_out_job),
		.q_pop(q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);
endmodule
`default_nettype wire
